[src/gamepad_change_event_generator_assert.svh]
// assertion macros for the gamepad change event generator
`ifndef GAMEPAD_CHANGE_EVENT_GENERATOR_ASSERT_SVH
`define GAMEPAD_CHANGE_EVENT_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define GCEV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked during reset as well
`define GCEV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GCEV_ASSERT(lbl, prop, msg)
`define GCEV_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[src/gcev_pkg.sv]
package gcev_pkg;

  localparam int NUM_AXES = 6;
  localparam int AXIS_W = 3;
  localparam logic [15:0] MAPPED_BITS = 16'hF3FF;
  localparam logic [31:0] PKT_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    EV_ADDED   = 3'd0,
    EV_REMOVED = 3'd1,
    EV_DOWN    = 3'd2,
    EV_UP      = 3'd3,
    EV_AXIS    = 3'd4
  } ev_kind_t;

  typedef struct packed {
    logic [1:0]         pad_slot;
    logic               present;
    logic [31:0]        packet_number;
    logic [15:0]        buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
  } report_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [1:0]         pad_id;
    logic [3:0]         event_code;
    logic signed [15:0] axis_level;
    logic               last_of_run;
  } evt_t;

  typedef struct packed {
    logic                           connected;
    logic [31:0]                    prev_packet;
    logic [15:0]                    prev_buttons;
    logic [NUM_AXES-1:0][15:0]      axes;
  } slot_state_t;

  // work handed from the update stage to the emitter
  typedef struct packed {
    logic [1:0]                slot;
    logic                      conn_ev;
    logic                      conn_removed;
    logic [15:0]               btn_mask;
    logic [15:0]               btn_new;
    logic [NUM_AXES-1:0]       axis_mask;
    logic [NUM_AXES-1:0][15:0] axes;
  } load_t;

  function automatic logic [3:0] btn_code(input logic [3:0] bit_idx);
    logic [3:0] code;
    case (bit_idx)
      4'd0:    code = 4'd11;
      4'd1:    code = 4'd12;
      4'd2:    code = 4'd13;
      4'd3:    code = 4'd14;
      4'd4:    code = 4'd6;
      4'd5:    code = 4'd4;
      4'd6:    code = 4'd7;
      4'd7:    code = 4'd8;
      4'd8:    code = 4'd9;
      4'd9:    code = 4'd10;
      4'd13:   code = 4'd1;
      4'd14:   code = 4'd2;
      4'd15:   code = 4'd3;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

  // floor(x * 32767 / 255) = 128x + floor(127x / 255)
  function automatic logic [15:0] trig_scale(input logic [7:0] x);
    logic [15:0] n;
    logic [16:0] q;
    n = 16'(x) * 16'd127;
    q = 17'(n) + 17'd1 + 17'(n >> 8);
    return {1'b0, x, 7'd0} + {8'd0, q[15:8]};
  endfunction

endpackage

[src/gcev_ram.sv]
module gcev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/gcev_update.sv]
module gcev_update (
  input  gcev_pkg::report_t     item,
  input  gcev_pkg::slot_state_t cur,
  input  logic                  in_range,
  output logic                  wr_en,
  output gcev_pkg::slot_state_t nxt,
  output gcev_pkg::load_t       ld
);

  logic [gcev_pkg::NUM_AXES-1:0][15:0] ax;
  logic [31:0]                         pkt_last;

  always_comb begin
    ax[0] = $unsigned(item.left_x);
    ax[1] = ~$unsigned(item.left_y);
    ax[2] = $unsigned(item.right_x);
    ax[3] = ~$unsigned(item.right_y);
    ax[4] = gcev_pkg::trig_scale(item.left_trigger);
    ax[5] = gcev_pkg::trig_scale(item.right_trigger);
  end

  assign pkt_last = cur.connected ? cur.prev_packet : gcev_pkg::PKT_ALL_ONES;

  always_comb begin
    nxt = cur;
    wr_en = 1'b0;
    ld = '0;
    ld.slot = item.pad_slot;
    if (in_range) begin
      if (!item.present) begin
        if (cur.connected) begin
          wr_en = 1'b1;
          nxt = '0;
          ld.conn_ev = 1'b1;
          ld.conn_removed = 1'b1;
        end
      end else begin
        wr_en = 1'b1;
        nxt.connected = 1'b1;
        nxt.prev_packet = pkt_last;
        ld.conn_ev = !cur.connected;
        if (item.packet_number != pkt_last) begin
          nxt.prev_packet = item.packet_number;
          nxt.prev_buttons = item.buttons;
          nxt.axes = ax;
          ld.btn_mask = (item.buttons ^ cur.prev_buttons) & gcev_pkg::MAPPED_BITS;
          ld.btn_new = item.buttons;
          ld.axes = ax;
          for (int a = 0; a < gcev_pkg::NUM_AXES; a++) begin
            ld.axis_mask[a] = (ax[a] != cur.axes[a]);
          end
        end
      end
    end
  end

endmodule

[src/gcev_emitter.sv]
`include "gamepad_change_event_generator_assert.svh"

module gcev_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            ld_valid,
  input  gcev_pkg::load_t ld,
  output logic            free,
  output logic            evt_valid,
  input  logic            evt_ready,
  output gcev_pkg::evt_t  evt
);

  logic                                conn_pend;
  logic                                conn_removed;
  logic [15:0]                         btn_mask;
  logic [15:0]                         btn_new;
  logic [gcev_pkg::NUM_AXES-1:0]       axis_mask;
  logic [gcev_pkg::NUM_AXES-1:0][15:0] axes;
  logic [1:0]                          slot;

  logic [15:0]                   btn_rest;
  logic [gcev_pkg::NUM_AXES-1:0] axis_rest;
  logic [3:0]                    btn_idx;
  logic [gcev_pkg::AXIS_W-1:0]   ax_idx;
  logic                          any_pend;
  logic                          can_issue;
  logic                          sel_last;
  gcev_pkg::evt_t                sel;

  assign btn_rest  = btn_mask & (btn_mask - 16'd1);
  assign axis_rest = axis_mask & (axis_mask - gcev_pkg::NUM_AXES'(1));
  assign any_pend  = conn_pend || (btn_mask != '0) || (axis_mask != '0);
  assign can_issue = any_pend && (!evt_valid || evt_ready);
  assign free      = !any_pend || (can_issue && sel_last);

  // lowest pending bit first
  always_comb begin
    btn_idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (btn_mask[i]) begin
        btn_idx = 4'(i);
      end
    end
    ax_idx = '0;
    for (int i = gcev_pkg::NUM_AXES - 1; i >= 0; i--) begin
      if (axis_mask[i]) begin
        ax_idx = gcev_pkg::AXIS_W'(i);
      end
    end
  end

  always_comb begin
    sel = '0;
    sel.pad_id = slot;
    if (conn_pend) begin
      sel.event_kind = conn_removed ? gcev_pkg::EV_REMOVED : gcev_pkg::EV_ADDED;
      sel_last = (btn_mask == '0) && (axis_mask == '0);
    end else if (btn_mask != '0) begin
      sel.event_kind = btn_new[btn_idx] ? gcev_pkg::EV_DOWN : gcev_pkg::EV_UP;
      sel.event_code = gcev_pkg::btn_code(btn_idx);
      sel_last = (btn_rest == '0) && (axis_mask == '0);
    end else begin
      sel.event_kind = gcev_pkg::EV_AXIS;
      sel.event_code = 4'(ax_idx);
      sel.axis_level = $signed(axes[ax_idx]);
      sel_last = (axis_rest == '0);
    end
    sel.last_of_run = sel_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_pend <= 1'b0;
      btn_mask <= '0;
      axis_mask <= '0;
      evt_valid <= 1'b0;
    end else begin
      if (ld_valid && free) begin
        conn_pend <= ld.conn_ev;
        btn_mask <= ld.btn_mask;
        axis_mask <= ld.axis_mask;
      end else if (can_issue) begin
        if (conn_pend) begin
          conn_pend <= 1'b0;
        end else if (btn_mask != '0) begin
          btn_mask <= btn_rest;
        end else begin
          axis_mask <= axis_rest;
        end
      end
      if (can_issue) begin
        evt_valid <= 1'b1;
      end else if (evt_ready) begin
        evt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && free) begin
      conn_removed <= ld.conn_removed;
      btn_new <= ld.btn_new;
      axes <= ld.axes;
      slot <= ld.slot;
    end
    if (can_issue) begin
      evt <= sel;
    end
  end

  `GCEV_ASSERT_RST(a_rst_idle, rst |=> !evt_valid && !conn_pend, "emitter not idle after reset")
  `GCEV_ASSERT(a_axis_code, evt_valid && evt.event_kind == gcev_pkg::EV_AXIS |-> evt.event_code < 4'd6, "axis event with bad index")
  `GCEV_ASSERT(a_conn_fields, evt_valid && (evt.event_kind == gcev_pkg::EV_ADDED || evt.event_kind == gcev_pkg::EV_REMOVED) |-> evt.event_code == 4'd0 && evt.axis_level == 16'sd0, "connection event with payload")

endmodule

[src/gamepad_change_event_generator.sv]
// channel  | valid / ready             | beat
// report   | report_valid/report_ready | gcev_pkg::report_t, one poll report
// evt      | evt_valid/evt_ready       | gcev_pkg::evt_t, one change event
//
// the slot memory is read at the report beat; the entry is updated and written back in the
// update stage as the report moves into the emitter, which sends one event beat per cycle
// unless evt stalls; a report holds the emitter until its last event (of at most 21) is sent,
// and one with none does not; evt_valid rises after the update stage and emitter registers
// reset clears per-slot valid flags at once, no clearing pass; a stalled evt holds the emitter
`include "gamepad_change_event_generator_assert.svh"

module gamepad_change_event_generator #(
  parameter int NUM_SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              report_valid,
  output logic              report_ready,
  input  gcev_pkg::report_t report,
  output logic              evt_valid,
  input  logic              evt_ready,
  output gcev_pkg::evt_t    evt
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int STATE_W = $bits(gcev_pkg::slot_state_t);

  logic                  accept;
  logic                  s1_valid;
  gcev_pkg::report_t     s1_item;
  logic                  s1_adv;
  logic                  rd_valid;
  logic                  fwd_hit;
  gcev_pkg::slot_state_t fwd_data;
  logic [NUM_SLOTS-1:0]  entry_valid;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SLOT_W-1:0]     wr_addr;
  logic                  rd_in_range;
  logic                  s1_in_range;
  logic [STATE_W-1:0]    rdata;
  logic                  ram_we;
  gcev_pkg::slot_state_t cur;
  gcev_pkg::slot_state_t nxt;
  logic                  upd_wr;
  gcev_pkg::load_t       ld;
  logic                  emit_free;

  assign rd_addr     = SLOT_W'(report.pad_slot);
  assign wr_addr     = SLOT_W'(s1_item.pad_slot);
  assign rd_in_range = ({30'd0, report.pad_slot} < 32'(NUM_SLOTS));
  assign s1_in_range = ({30'd0, s1_item.pad_slot} < 32'(NUM_SLOTS));

  assign s1_adv       = s1_valid && emit_free;
  assign report_ready = !s1_valid || s1_adv;
  assign accept       = report_valid && report_ready;
  assign ram_we       = s1_adv && upd_wr;

  // same-slot write at the read edge is forwarded
  always_comb begin
    if (!s1_in_range) begin
      cur = '0;
    end else if (fwd_hit) begin
      cur = fwd_data;
    end else if (rd_valid) begin
      cur = gcev_pkg::slot_state_t'(rdata);
    end else begin
      cur = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      entry_valid <= '0;
      fwd_hit <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit <= ram_we && (wr_addr == rd_addr);
        rd_valid <= rd_in_range && entry_valid[rd_addr];
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (ram_we) begin
        entry_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= report;
      fwd_data <= nxt;
    end
  end

  gcev_ram #(
    .WIDTH(STATE_W),
    .DEPTH(NUM_SLOTS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_addr),
    .wdata(STATE_W'(nxt)),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  gcev_update u_update (
    .item    (s1_item),
    .cur     (cur),
    .in_range(s1_in_range),
    .wr_en   (upd_wr),
    .nxt     (nxt),
    .ld      (ld)
  );

  gcev_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .ld_valid (s1_adv),
    .ld       (ld),
    .free     (emit_free),
    .evt_valid(evt_valid),
    .evt_ready(evt_ready),
    .evt      (evt)
  );

  `GCEV_ASSERT_RST(a_rst_clear, rst |=> !s1_valid && entry_valid == '0, "pipeline not cleared by reset")
  `GCEV_ASSERT(a_range_nowrite, s1_valid && !s1_in_range |-> !ram_we, "write for a slot out of range")
  `GCEV_ASSERT(a_s1_hold, s1_valid && !s1_adv |=> s1_valid && $stable(s1_item), "update stage lost a stalled report")

endmodule

[bench/tb_gamepad_change_event_generator.sv]
module tb_gamepad_change_event_generator;

  localparam int SLOT_COUNT = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 200;
  // canonical index per raw button bit, bit 0 in the low nibble
  localparam logic [63:0] BUTTON_INDEX = {
    4'd3, 4'd2, 4'd1, 4'd0, 4'd0, 4'd0, 4'd10, 4'd9,
    4'd8, 4'd7, 4'd4, 4'd6, 4'd14, 4'd13, 4'd12, 4'd11
  };

  logic              clk;
  logic              rst;
  logic              report_valid;
  logic              report_ready;
  gcev_pkg::report_t report;
  logic              evt_valid;
  logic              evt_ready;
  gcev_pkg::evt_t    evt;

  gamepad_change_event_generator #(.NUM_SLOTS(SLOT_COUNT)) uut (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report),
    .evt_valid    (evt_valid),
    .evt_ready    (evt_ready),
    .evt          (evt)
  );

  // predicted slot contents
  logic        pad_connected [SLOT_COUNT];
  logic [31:0] pad_last_pkt  [SLOT_COUNT];
  logic [15:0] pad_last_btn  [SLOT_COUNT];
  logic [15:0] pad_last_axis [SLOT_COUNT][gcev_pkg::NUM_AXES];

  // current controller contents used to build plausible polls
  gcev_pkg::report_t pad_now [SLOT_COUNT];

  gcev_pkg::evt_t pending_events [$];
  int   fail_count;
  int   reports_sent;
  int   events_checked;
  int   kind_count [5];
  int   idle_cycles;
  bit   rpt_idle_on;
  bit   evt_idle_on;
  int   evt_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic gcev_pkg::evt_t make_event(input gcev_pkg::ev_kind_t kind, input int slot,
                                                input int code, input logic [15:0] value);
    gcev_pkg::evt_t e;
    e.event_kind  = kind;
    e.pad_id      = 2'(slot);
    e.event_code  = 4'(code);
    e.axis_level  = value;
    e.last_of_run = 1'b0;
    return e;
  endfunction

  function automatic void clear_pad(input int s);
    int a;
    pad_connected[s] = 1'b0;
    pad_last_pkt[s]  = '0;
    pad_last_btn[s]  = '0;
    for (a = 0; a < gcev_pkg::NUM_AXES; a++) pad_last_axis[s][a] = '0;
  endfunction

  function automatic void predict_events(input gcev_pkg::report_t r);
    gcev_pkg::evt_t run [$];
    logic [15:0]    diff;
    logic [15:0]    nxt [gcev_pkg::NUM_AXES];
    int             s;
    int             b;
    int             a;
    s = int'(r.pad_slot);
    if (!r.present) begin
      if (pad_connected[s]) begin
        run.push_back(make_event(gcev_pkg::EV_REMOVED, s, 0, '0));
        clear_pad(s);
      end
    end else begin
      if (!pad_connected[s]) begin
        run.push_back(make_event(gcev_pkg::EV_ADDED, s, 0, '0));
        pad_connected[s] = 1'b1;
        pad_last_pkt[s]  = gcev_pkg::PKT_ALL_ONES;
      end
      if (r.packet_number != pad_last_pkt[s]) begin
        pad_last_pkt[s] = r.packet_number;
        diff = (r.buttons ^ pad_last_btn[s]) & gcev_pkg::MAPPED_BITS;
        for (b = 0; b < 16; b++) begin
          if (diff[b])
            run.push_back(make_event(r.buttons[b] ? gcev_pkg::EV_DOWN : gcev_pkg::EV_UP, s,
                                     int'(BUTTON_INDEX[b*4 +: 4]), '0));
        end
        pad_last_btn[s] = r.buttons;
        nxt[0] = r.left_x;
        nxt[1] = ~r.left_y;
        nxt[2] = r.right_x;
        nxt[3] = ~r.right_y;
        nxt[4] = 16'((int'(r.left_trigger) * 32767) / 255);
        nxt[5] = 16'((int'(r.right_trigger) * 32767) / 255);
        for (a = 0; a < gcev_pkg::NUM_AXES; a++) begin
          if (nxt[a] != pad_last_axis[s][a]) begin
            run.push_back(make_event(gcev_pkg::EV_AXIS, s, a, nxt[a]));
            pad_last_axis[s][a] = nxt[a];
          end
        end
      end
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) pending_events.push_back(run[i]);
  endfunction

  function automatic gcev_pkg::report_t make_report(input int slot, input bit present,
                                          input logic [31:0] pkt, input logic [15:0] btn,
                                          input logic [15:0] lx, input logic [15:0] ly,
                                          input logic [15:0] rx, input logic [15:0] ry,
                                          input logic [7:0] lt, input logic [7:0] rt);
    gcev_pkg::report_t r;
    r.pad_slot      = 2'(slot);
    r.present       = present;
    r.packet_number = pkt;
    r.buttons       = btn;
    r.left_x        = lx;
    r.left_y        = ly;
    r.right_x       = rx;
    r.right_y       = ry;
    r.left_trigger  = lt;
    r.right_trigger = rt;
    return r;
  endfunction

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_trigger();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic gcev_pkg::report_t random_report();
    return make_report($urandom_range(0, 3), 1'($urandom_range(0, 1)), $urandom,
                       16'($urandom), pick_axis(), pick_axis(), pick_axis(), pick_axis(),
                       pick_trigger(), pick_trigger());
  endfunction

  // next poll of a pad: mostly fresh packets with small changes
  function automatic gcev_pkg::report_t next_report(input int s);
    gcev_pkg::report_t r;
    int                roll;
    r    = pad_now[s];
    roll = $urandom_range(0, 99);
    if (!r.present) begin
      r = random_report();
      r.present = 1'b1;
    end else if (roll < 6) begin
      r.present = 1'b0;
    end else if (roll < 14) begin
      r.buttons = 16'($urandom);
      r.left_x  = pick_axis();
    end else begin
      r.packet_number = r.packet_number + ((roll < 90) ? 32'd1 : 32'($urandom_range(2, 999)));
      r.buttons = r.buttons ^ 16'(1 << $urandom_range(0, 15));
      if ($urandom_range(0, 4) == 0) r.buttons = r.buttons ^ 16'($urandom);
      if ($urandom_range(0, 2) == 0) r.left_x = pick_axis();
      if ($urandom_range(0, 2) == 0) r.left_y = pick_axis();
      if ($urandom_range(0, 2) == 0) r.right_x = pick_axis();
      if ($urandom_range(0, 2) == 0) r.right_y = pick_axis();
      if ($urandom_range(0, 2) == 0) r.left_trigger = pick_trigger();
      if ($urandom_range(0, 2) == 0) r.right_trigger = pick_trigger();
    end
    r.pad_slot = 2'(s);
    pad_now[s] = r;
    return r;
  endfunction

  task automatic send_report(input gcev_pkg::report_t r);
    int gap;
    gap = rpt_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      report_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    report       <= r;
    report_valid <= 1'b1;
    @(posedge clk);
    while (!report_ready) @(posedge clk);
    predict_events(r);
    reports_sent++;
  endtask

  task automatic drain_events();
    report_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    send_report(make_report(0, 0, 32'd1, 16'hFFFF, 0, 0, 0, 0, 0, 0));
    // worst case: added, every mapped button down, every axis moves
    send_report(make_report(0, 1, 32'd5, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000,
                            16'h7FFF, 8'd255, 8'd255));
    send_report(make_report(0, 1, 32'd5, 16'h0000, 0, 0, 0, 0, 0, 0));
    send_report(make_report(0, 1, 32'd6, 16'h0000, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0));
    // unmapped buttons only
    send_report(make_report(0, 1, 32'd7, 16'h0C00, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0));
    send_report(make_report(0, 1, 32'd8, 16'h0000, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0));
    send_report(make_report(0, 1, 32'd9, 16'h0001, 16'hFFFF, 16'hFFFF, 0, 16'h0000,
                            8'd1, 8'd254));
    send_report(make_report(0, 1, 32'd10, 16'h4000, 16'hFFFF, 16'hFFFF, 0, 16'h0000,
                            8'd128, 8'd127));
    send_report(make_report(0, 0, 32'd10, 16'h0000, 0, 0, 0, 0, 0, 0));
    send_report(make_report(0, 0, 32'd11, 16'h0000, 0, 0, 0, 0, 0, 0));
    // first poll carrying an all-ones packet number
    send_report(make_report(1, 1, 32'hFFFF_FFFF, 16'hFFFF, 16'h1234, 0, 0, 0, 8'd9, 0));
    send_report(make_report(1, 1, 32'hFFFF_FFFF, 16'hFFFF, 16'h1234, 0, 0, 0, 8'd9, 0));
    send_report(make_report(1, 1, 32'h0000_0000, 16'hFFFF, 16'h1234, 0, 0, 0, 8'd9, 0));
    send_report(make_report(2, 1, 32'h0000_0000, 16'h0000, 0, 0, 0, 0, 0, 0));
    send_report(make_report(3, 0, 32'h0000_0000, 16'h0000, 0, 0, 0, 0, 0, 0));
    send_report(make_report(3, 1, 32'h8000_0000, 16'h8001, 16'h8000, 16'h7FFF,
                            16'h7FFF, 16'h8000, 8'd0, 8'd255));
    send_report(make_report(3, 1, 32'h8000_0001, 16'h0402, 16'h8000, 16'h7FFF,
                            16'h7FFF, 16'h8000, 8'd0, 8'd255));
    send_report(make_report(3, 1, 32'hAAAA_5555, 16'h5A5A, 16'h0001, 16'hFFFE,
                            16'h5555, 16'hAAAA, 8'h55, 8'hAA));
    send_report(make_report(2, 0, 32'h0, 16'h0, 0, 0, 0, 0, 0, 0));
    send_report(make_report(1, 0, 32'h0, 16'h0, 0, 0, 0, 0, 0, 0));
    send_report(make_report(3, 0, 32'h0, 16'h0, 0, 0, 0, 0, 0, 0));
    drain_events();
  endtask

  task automatic test_sessions(input int count);
    int i;
    for (i = 0; i < count; i++) send_report(next_report($urandom_range(0, 3)));
    drain_events();
  endtask

  task automatic test_no_idle();
    rpt_idle_on = 1'b0;
    evt_idle_on = 1'b0;
    test_sessions(30);
    rpt_idle_on = 1'b1;
    evt_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    int i;
    rpt_idle_on  = 1'b0;
    evt_hold_req = LONG_HOLD_CYCLES;
    for (i = 0; i < 20; i++) send_report(next_report($urandom_range(0, 3)));
    drain_events();
    evt_hold_req = 0;
    rpt_idle_on  = 1'b1;
  endtask

  task automatic test_noise();
    int i;
    for (i = 0; i < 25; i++) send_report(random_report());
    drain_events();
  endtask

  // event sink with random and long stalls
  initial begin : evt_sink
    int wait_cycles;
    evt_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (evt_hold_req > 0) begin
        wait_cycles  = evt_hold_req;
        evt_hold_req = 0;
      end else begin
        wait_cycles = evt_idle_on ? $urandom_range(0, 5) : 0;
      end
      if (wait_cycles > 0) begin
        evt_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      evt_ready <= 1'b1;
      @(posedge clk);
      while (!evt_valid) @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : evt_check
    gcev_pkg::evt_t want;
    if (!rst && evt_valid && evt_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected beat: kind %0d pad %0d code %0d", evt.event_kind, evt.pad_id,
               evt.event_code);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", int'(want.event_kind), int'(evt.event_kind));
        check_field("pad_id", int'(want.pad_id), int'(evt.pad_id));
        check_field("event_code", int'(want.event_code), int'(evt.event_code));
        check_field("axis_level", int'(want.axis_level), int'(evt.axis_level));
        check_field("last_of_run", int'(want.last_of_run), int'(evt.last_of_run));
        events_checked++;
        if (want.event_kind <= gcev_pkg::EV_AXIS) kind_count[want.event_kind]++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (report_valid && report_ready) || (evt_valid && evt_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** gamepad_change_event_generator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int s;
    rst            <= 1'b1;
    report_valid   <= 1'b0;
    report         <= '0;
    fail_count     = 0;
    reports_sent   = 0;
    events_checked = 0;
    rpt_idle_on    = 1'b1;
    evt_idle_on    = 1'b1;
    evt_hold_req   = 0;
    foreach (kind_count[k]) kind_count[k] = 0;
    for (s = 0; s < SLOT_COUNT; s++) begin
      clear_pad(s);
      pad_now[s] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_sessions(190);
    test_no_idle();
    test_backpressure();
    test_noise();

    $display("covered %0d poll reports, %0d events checked", reports_sent, events_checked);
    $display("added %0d removed %0d down %0d up %0d axis %0d, with long sink stalls",
             kind_count[gcev_pkg::EV_ADDED], kind_count[gcev_pkg::EV_REMOVED],
             kind_count[gcev_pkg::EV_DOWN], kind_count[gcev_pkg::EV_UP],
             kind_count[gcev_pkg::EV_AXIS]);
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("** gamepad_change_event_generator: PASSED **");
    end else begin
      $display("** gamepad_change_event_generator: FAILED **");
    end
    $finish;
  end

endmodule
